// File: rtl/core/xwn_pkg.sv
// ============================================================================
// xwn_pkg: shared types and constants of the whitespace normalizer
// Holds the channel payload types, the queue entry type, mode codes and the
// whitespace byte codes used by the front and back stages.
// ============================================================================
package xwn_pkg;

   // Mode register codes. The unused code acts as preserve.
   localparam logic [1:0] MODE_PRESERVE = 2'd0;
   localparam logic [1:0] MODE_REPLACE  = 2'd1;
   localparam logic [1:0] MODE_COLLAPSE = 2'd2;

   // Whitespace bytes.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   typedef struct packed {
      logic [7:0] char_in;
      logic       has_byte;
      logic       end_of_literal;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       byte_valid;
      logic       last;
   } rsp_type;

   // One queue entry stands for all results of one input transaction:
   // an optional leading space, then the stored result.
   typedef struct packed {
      logic    space_first;
      rsp_type res;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
   endfunction

endpackage

// File: rtl/core/xml_whitespace_normalizer_core.sv
// ============================================================================
// xml_whitespace_normalizer_core: streaming whitespace normalizer
// Normalizes space, tab, LF and CR in text literals by a mode register.
// ============================================================================
// Usage:
// The req channel takes one byte of a literal per transaction, with has_byte
// telling whether char_in carries a byte and end_of_literal closing the
// literal. The rsp channel returns normalized bytes; last marks the final
// result of a literal, and a result with byte_valid low is a bare end marker.
// The csr port writes the 2-bit mode (0 preserve, 1 replace runs with one
// space, 2 collapse and trim ends, 3 acts as preserve). Write it only while
// the block is idle.
// An accepted request is written into the queue and from there loaded into
// the output register. The front accepts one transaction per cycle while
// the queue has room. Throughput is bound by the single output register:
// the back issues one result per cycle while the receiver takes them, so a
// byte with a leading held space gives two results, the space first.
// Reset clears the mode to preserve, the per-literal flags, the queue and
// the output register. When the receiver stalls, the output register holds
// its result, the queue fills, and req_ready drops once DEPTH entries wait.
// ============================================================================
module xml_whitespace_normalizer_core #(
   // Queue entries between front and back; at least 2.
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  xwn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xwn_pkg::rsp_type rsp_data
);
   import xwn_pkg::*;

   // Front to queue: one entry per transaction that produces any result.
   logic             push;
   entry_type        push_data;
   // Queue to back: the head entry and a pop when it is fully issued.
   logic             pop;
   entry_type        head;
   queue_status_type q_status;

   xwn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   xwn_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   xwn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The front only stalls when the queue is full.
   a_ready_tracks_queue: assert property (@(posedge clock) disable iff (reset)
      req_ready == q_status.not_full)
      else $error("req_ready does not follow queue space");

   // An end transaction always leaves an entry behind.
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.end_of_literal) |-> push)
      else $error("end of literal produced no entry");

   // A queued entry reaches the output register when it is free.
   a_issue_when_free: assert property (@(posedge clock) disable iff (reset)
      (q_status.not_empty && !rsp_valid) |=> rsp_valid)
      else $error("queued entry not issued");

endmodule

// File: rtl/core/xwn_front.sv
// ============================================================================
// xwn_front: accept and classify stage
// Holds the mode register and the per-literal flags, and turns each accepted
// transaction into at most one queue entry.
// ============================================================================
module xwn_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  xwn_pkg::req_type          req_data,
   input  xwn_pkg::queue_status_type q_status,
   output logic                      push,
   output xwn_pkg::entry_type        push_data
);
   import xwn_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic       prev_was_space_ff, prev_was_space_in;
   logic       space_pending_ff, space_pending_in;
   logic       content_seen_ff, content_seen_in;
   logic       accept;
   logic       emit;
   logic       ws;
   entry_type  entry;

   assign req_ready = q_status.not_full;
   assign accept    = req_valid && req_ready;
   assign ws        = is_ws(req_data.char_in);

   always_comb begin
      emit              = 1'b0;
      entry.space_first = 1'b0;
      entry.res         = '{char_out: req_data.char_in, byte_valid: 1'b1, last: 1'b0};
      prev_was_space_in = prev_was_space_ff;
      space_pending_in  = space_pending_ff;
      content_seen_in   = content_seen_ff;
      mode_in           = csr_wr_en ? csr_wr_data : mode_ff;

      if (req_data.has_byte) begin
         case (mode_ff)
            MODE_REPLACE: begin
               if (ws) begin
                  emit               = !prev_was_space_ff;
                  entry.res.char_out = CHAR_SPACE;
                  prev_was_space_in  = 1'b1;
               end else begin
                  emit              = 1'b1;
                  prev_was_space_in = 1'b0;
               end
            end
            MODE_COLLAPSE: begin
               if (ws) begin
                  if (content_seen_ff) begin
                     space_pending_in = 1'b1;
                  end
               end else begin
                  emit              = 1'b1;
                  entry.space_first = space_pending_ff;
                  space_pending_in  = 1'b0;
                  content_seen_in   = 1'b1;
               end
            end
            default: begin
               emit = 1'b1;
            end
         endcase
      end

      if (req_data.end_of_literal) begin
         if (emit) begin
            entry.res.last = 1'b1;
         end else begin
            entry.res = '{char_out: CHAR_NONE, byte_valid: 1'b0, last: 1'b1};
         end
         prev_was_space_in = 1'b0;
         space_pending_in  = 1'b0;
         content_seen_in   = 1'b0;
      end
   end

   assign push      = accept && (emit || req_data.end_of_literal);
   assign push_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_PRESERVE;
         prev_was_space_ff <= 1'b0;
         space_pending_ff  <= 1'b0;
         content_seen_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            prev_was_space_ff <= prev_was_space_in;
            space_pending_ff  <= space_pending_in;
            content_seen_ff   <= content_seen_in;
         end
      end
   end

   // A pending space only exists after content has been seen.
   a_pending_needs_content: assert property (@(posedge clock) disable iff (reset)
      space_pending_ff |-> content_seen_ff)
      else $error("space pending without content");

   // A leading space is only queued ahead of a real byte.
   a_space_first_byte: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.space_first) |-> push_data.res.byte_valid)
      else $error("leading space without byte");

   // Flags are cleared once a literal closes.
   a_flags_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.end_of_literal) |=>
      (!prev_was_space_ff && !space_pending_ff && !content_seen_ff))
      else $error("flags not cleared at end of literal");

endmodule

// File: rtl/core/xwn_queue.sv
// ============================================================================
// xwn_queue: entry queue between front and back
// A small register FIFO with head read at the read pointer.
// ============================================================================
module xwn_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  xwn_pkg::entry_type        push_data,
   input  logic                      pop,
   output xwn_pkg::entry_type        head,
   output xwn_pkg::queue_status_type status
);
   import xwn_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.not_full  = (count_ff != CNT_W'(DEPTH));

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (status.not_full || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.not_empty)
      else $error("queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");

endmodule

// File: rtl/core/xwn_back.sv
// ============================================================================
// xwn_back: result issue stage
// Drains queue entries into the output register, one result per cycle while
// the receiver takes them, splitting an entry with a leading space into two results.
// ============================================================================
module xwn_back (
   input  logic                      clock,
   input  logic                      reset,
   input  xwn_pkg::entry_type        head,
   input  xwn_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output xwn_pkg::rsp_type          rsp_data
);
   import xwn_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    space_done_ff, space_done_in;
   logic    load;

   assign load = q_status.not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      space_done_in = space_done_ff;
      pop           = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (head.space_first && !space_done_ff) begin
            rsp_in        = '{char_out: CHAR_SPACE, byte_valid: 1'b1, last: 1'b0};
            space_done_in = 1'b1;
         end else begin
            rsp_in        = head.res;
            space_done_in = 1'b0;
            pop           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         space_done_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         space_done_ff <= space_done_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Half-issued entry stays at the head of the queue.
   a_space_done_head: assert property (@(posedge clock) disable iff (reset)
      space_done_ff |-> (q_status.not_empty && head.space_first))
      else $error("leading space issued but entry missing");

   // After the leading space the same entry's byte follows next.
   a_space_then_pop: assert property (@(posedge clock) disable iff (reset)
      (space_done_ff && load) |-> pop)
      else $error("entry not completed after leading space");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.byte_valid) |-> (rsp_ff.last && rsp_ff.char_out == CHAR_NONE))
      else $error("bare end marker malformed");

endmodule

// File: test/xml_whitespace_normalizer_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// xml_whitespace_normalizer_core_tb: self-checking bench for the normalizer
// Drives byte transactions through the req channel under every mode, predicts
// each normalized result in a scoreboard and compares it with the rsp channel.
// ============================================================================
module xml_whitespace_normalizer_core_tb;
   import xwn_pkg::*;

   // The unused mode code has no name in the package; it must act as preserve.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int  HALF_PERIOD   = 2;
   localparam int  RESET_CYCLES  = 8;
   // Cycles to wait after the last expected result before the mode may change.
   // Items that yield no result never enter the block's queue, so this only
   // adds margin on top of a full queue of four entries.
   localparam int  SETTLE_CYCLES = 12;
   localparam int  PHASE_ITEMS   = 125;
   localparam int  PHASE_COUNT   = 12;
   localparam int  STEADY_PHASE  = 5;
   localparam int  IDLE_PCT      = 12;
   localparam int  REPORT_LIMIT  = 10;
   localparam time RUN_LIMIT     = 1_000_000;

   // ------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the mode and the per-literal flags,
   // turns each accepted request into the results it must cause, and holds
   // them in order until the rsp channel delivers them.
   // ------------------------------------------------------------------------
   class normalizer_scoreboard;
      logic [1:0] mode;
      bit         run_space;   // replace: the last byte sent out was a space
      bit         held_space;  // collapse: a space waits for more content
      bit         text_seen;   // collapse: content already went out
      rsp_type    due_q[$];
      int         errors;

      function new();
         mode = MODE_PRESERVE;
         clear_literal();
         errors = 0;
      endfunction

      function void clear_literal();
         run_space  = 1'b0;
         held_space = 1'b0;
         text_seen  = 1'b0;
      endfunction

      function void set_mode(logic [1:0] value);
         mode = value;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
      endfunction

      function rsp_type make_rsp(logic [7:0] c, logic valid, logic fin);
         rsp_type r;
         r.char_out   = c;
         r.byte_valid = valid;
         r.last       = fin;
         return r;
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      function void note_request(req_type item);
         rsp_type step_q[$];
         rsp_type r;
         if (item.has_byte) begin
            case (mode)
               MODE_REPLACE: begin
                  if (is_blank(item.char_in)) begin
                     if (!run_space) step_q.push_back(make_rsp(CHAR_SPACE, 1'b1, 1'b0));
                     run_space = 1'b1;
                  end else begin
                     step_q.push_back(make_rsp(item.char_in, 1'b1, 1'b0));
                     run_space = 1'b0;
                  end
               end
               MODE_COLLAPSE: begin
                  if (is_blank(item.char_in)) begin
                     if (text_seen) held_space = 1'b1;
                  end else begin
                     if (held_space) step_q.push_back(make_rsp(CHAR_SPACE, 1'b1, 1'b0));
                     step_q.push_back(make_rsp(item.char_in, 1'b1, 1'b0));
                     held_space = 1'b0;
                     text_seen  = 1'b1;
                  end
               end
               default: begin
                  step_q.push_back(make_rsp(item.char_in, 1'b1, 1'b0));
               end
            endcase
         end
         if (item.end_of_literal) begin
            // Nothing went out on the closing step, so a bare end marker does.
            if (step_q.size() == 0) step_q.push_back(make_rsp(CHAR_NONE, 1'b0, 1'b1));
            clear_literal();
         end
         foreach (step_q[i]) begin
            r = step_q[i];
            if (item.end_of_literal && i == step_q.size() - 1) r.last = 1'b1;
            due_q.push_back(r);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result: char %02h valid %0b last %0b",
                        got.char_out, got.byte_valid, got.last);
            return;
         end
         want = due_q.pop_front();
         if (got.char_out !== want.char_out || got.byte_valid !== want.byte_valid ||
             got.last !== want.last) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("result mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                        want.char_out, want.byte_valid, want.last,
                        got.char_out, got.byte_valid, got.last);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and the block's inputs. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_wr_data = MODE_PRESERVE;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;

   normalizer_scoreboard board = new();

   // Idle percentage shared by both sides; it drops to zero for a steady phase.
   int idle_pct    = IDLE_PCT;
   int phase_items = 0;

   always #HALF_PERIOD clock = ~clock;

   xml_whitespace_normalizer_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // The receiver stalls at random; the decision is made at the falling edge
   // so it is stable when the rising edge samples the handshake.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // A result transaction completes at a rising edge with valid and ready high.
   // Values read here are the ones from before the edge, since the block
   // updates its registers with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Hard stop in case the block hangs or loses results.
   initial begin
      #RUN_LIMIT;
      $display("simulation failed");
      $finish;
   end

   function automatic req_type make_req(logic [7:0] c, logic hb, logic eol);
      req_type r;
      r.char_in        = c;
      r.has_byte       = hb;
      r.end_of_literal = eol;
      return r;
   endfunction

   // Whitespace shows up often enough to form runs of it.
   function automatic logic [7:0] random_byte();
      logic [7:0] c;
      if ($urandom_range(99) < 40) begin
         case ($urandom_range(3))
            0:       c = CHAR_SPACE;
            1:       c = CHAR_TAB;
            2:       c = CHAR_LF;
            default: c = CHAR_CR;
         endcase
      end else begin
         c = 8'($urandom_range(255));
      end
      return c;
   endfunction

   // Presents one request transaction, possibly after idling at random, and
   // returns at the falling edge after it was accepted. Valid stays high on
   // return so that back-to-back items never drop it in between.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
      // Items that carry no byte and close nothing are ignored by the block.
      if (item.has_byte || item.end_of_literal) phase_items++;
      @(negedge clock);
   endtask

   // Holds the sender off until every expected result has come back, then
   // lets the block settle; items with no result never enter its queue.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_mode(input logic [1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.set_mode(value);
   endtask

   task automatic change_mode(input logic [1:0] value);
      drain_and_settle();
      write_mode(value);
   endtask

   // One well-formed literal with random content. Most close on their last
   // byte; some close with a separate end marker, and empty ones are just that
   // marker. Ignored empty items are sprinkled in between.
   task automatic send_literal();
      int len;
      bit split_end;
      len       = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(10);
      split_end = (len == 0) || ($urandom_range(4) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 6)
            send_item(make_req(8'($urandom_range(255)), 1'b0, 1'b0));
         send_item(make_req(random_byte(), 1'b1, (i == len - 1) && !split_end));
      end
      if (split_end) send_item(make_req(8'($urandom_range(255)), 1'b0, 1'b1));
   endtask

   // Noise: every field at random, so literals get cut or closed anywhere.
   task automatic send_noise();
      int count;
      count = $urandom_range(1, 8);
      repeat (count) send_item(make_req(8'($urandom_range(255)), 1'($urandom_range(1)),
                                        1'($urandom_range(1))));
   endtask

   initial begin
      logic [1:0] phase_mode [PHASE_COUNT];
      phase_mode = '{MODE_PRESERVE, MODE_REPLACE, MODE_COLLAPSE, MODE_UNUSED,
                     MODE_COLLAPSE, MODE_REPLACE, MODE_COLLAPSE, MODE_PRESERVE,
                     MODE_REPLACE, MODE_COLLAPSE, MODE_UNUSED, MODE_COLLAPSE};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---------------------------------------------------------------------
      // Directed part. Preserve first: byte extremes, whitespace untouched,
      // a bare end marker for an empty literal and an ignored empty item.
      // ---------------------------------------------------------------------
      write_mode(MODE_PRESERVE);
      send_item(make_req(8'h00, 1'b1, 1'b0));
      send_item(make_req(8'hFF, 1'b1, 1'b0));
      send_item(make_req(CHAR_TAB, 1'b1, 1'b1));
      send_item(make_req(8'hA5, 1'b0, 1'b1));
      send_item(make_req(8'h5A, 1'b0, 1'b0));

      // Replace: a leading run becomes one space, a trailing space carries the
      // last flag, and a run merged at the end leaves a bare end marker.
      change_mode(MODE_REPLACE);
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b0));
      send_item(make_req(CHAR_LF, 1'b1, 1'b0));
      send_item(make_req(8'h41, 1'b1, 1'b0));
      send_item(make_req(CHAR_CR, 1'b1, 1'b1));
      send_item(make_req(CHAR_TAB, 1'b1, 1'b0));
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b1));

      // Collapse: leading whitespace dropped, an inner run held and sent as
      // one space ahead of the closing byte (two results, last on the byte),
      // and trimmed endings giving bare end markers.
      change_mode(MODE_COLLAPSE);
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b0));
      send_item(make_req(8'h61, 1'b1, 1'b0));
      send_item(make_req(CHAR_TAB, 1'b1, 1'b0));
      send_item(make_req(CHAR_LF, 1'b1, 1'b0));
      send_item(make_req(8'h62, 1'b1, 1'b1));
      send_item(make_req(CHAR_CR, 1'b1, 1'b0));
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b1));
      send_item(make_req(8'h63, 1'b1, 1'b0));
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b1));

      // Mode change inside an open literal: the held space of collapse must
      // survive a stretch in replace mode, which uses only its own flag.
      send_item(make_req(8'h78, 1'b1, 1'b0));
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b0));
      change_mode(MODE_REPLACE);
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b0));
      change_mode(MODE_COLLAPSE);
      send_item(make_req(8'h79, 1'b1, 1'b1));

      // The unused mode code passes bytes through like preserve.
      change_mode(MODE_UNUSED);
      send_item(make_req(CHAR_SPACE, 1'b1, 1'b0));
      send_item(make_req(8'h80, 1'b1, 1'b1));

      // ---------------------------------------------------------------------
      // Random part, in phases with one mode each. Mostly well-formed
      // literals, some noise, and now and then a full drain mid-phase. One
      // phase runs with no idling on either side.
      // ---------------------------------------------------------------------
      for (int p = 0; p < PHASE_COUNT; p++) begin
         change_mode(phase_mode[p]);
         idle_pct    = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) send_literal();
            else send_noise();
            if ($urandom_range(49) == 0) drain_and_settle();
         end
      end

      // Every result must come back, and nothing extra may follow.
      drain_and_settle();
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
